### src/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg: shared types and constants for the gain command parser
// Character codes, parse phases, decimal scale table and the result word.
// ----------------------------------------------------------------------------
package gcp_pkg;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int GAIN_W = 32;
	localparam int MAG_W  = 31;
	localparam int SUM_W  = 36;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// powers of ten up to 10^6; last entry unused
	localparam logic [23:0] POW10 [8] = '{
		24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd0
	};

	typedef enum logic [4:0] {
		PH_AT   = 5'b00001,
		PH_SEL  = 5'b00010,
		PH_NUM  = 5'b00100,
		PH_DONE = 5'b01000,
		PH_FAIL = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              status;
		logic              target_gain;
		logic [GAIN_W-1:0] angular;
		logic [GAIN_W-1:0] linear;
	} result_t;

endpackage

### src/gcp_parse_core.sv
// ----------------------------------------------------------------------------
// gcp_parse_core: command parse state and gain registers
// Consumes one word per step; on a final word gives the verdict and gains.
// ----------------------------------------------------------------------------
module gcp_parse_core #(
	parameter int MAX_NUMBER_CHARS = 31,
	parameter int FRACTION_DIGITS  = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       char_byte,
	input  logic             is_final,
	output gcp_pkg::result_t result
);

	localparam int NCW = $clog2(MAX_NUMBER_CHARS + 1);
	localparam int FDW = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
	localparam logic [gcp_pkg::SUM_W-1:0] TEN = gcp_pkg::SUM_W'(10);
	localparam logic [gcp_pkg::SUM_W-1:0] INT_SCALE =
		gcp_pkg::SUM_W'(gcp_pkg::POW10[FRACTION_DIGITS]);

	gcp_pkg::phase_t             phase_q, phase_d;
	logic [NCW-1:0]              nc_q, nc_d;
	logic                        sel_q, sel_d;
	logic                        neg_q, neg_d;
	logic                        point_q, point_d;
	logic [FDW-1:0]              fd_q, fd_d;
	logic [gcp_pkg::MAG_W-1:0]   mag_q, mag_d;
	logic [gcp_pkg::GAIN_W-1:0]  ang_q, ang_d;
	logic [gcp_pkg::GAIN_W-1:0]  lin_q, lin_d;

	logic                        is_digit;
	logic [gcp_pkg::SUM_W-1:0]   digit;
	logic [gcp_pkg::SUM_W-1:0]   mag_ext;
	logic [gcp_pkg::SUM_W-1:0]   frac_scale;
	logic [gcp_pkg::SUM_W-1:0]   sum;
	logic [2:0]                  frac_idx;
	logic [gcp_pkg::GAIN_W-1:0]  value;
	logic                        ok;

	assign is_digit   = char_byte inside {[gcp_pkg::CH_ZERO:gcp_pkg::CH_NINE]};
	assign digit      = gcp_pkg::SUM_W'(char_byte[3:0]);
	assign mag_ext    = gcp_pkg::SUM_W'(mag_q);
	assign frac_idx   = 3'(FRACTION_DIGITS - 1) - 3'(fd_q);
	assign frac_scale = gcp_pkg::SUM_W'(gcp_pkg::POW10[frac_idx]);

	always_comb begin
		phase_d = phase_q;
		nc_d    = nc_q;
		sel_d   = sel_q;
		neg_d   = neg_q;
		point_d = point_q;
		fd_d    = fd_q;
		mag_d   = mag_q;
		ang_d   = ang_q;
		lin_d   = lin_q;
		sum     = mag_ext;
		ok      = 1'b0;
		value   = '0;

		case (phase_q)
			gcp_pkg::PH_AT: begin
				phase_d = (char_byte == gcp_pkg::CH_AT) ? gcp_pkg::PH_SEL : gcp_pkg::PH_FAIL;
			end
			gcp_pkg::PH_SEL: begin
				if (char_byte == gcp_pkg::CH_F) begin
					sel_d   = 1'b0;
					phase_d = gcp_pkg::PH_NUM;
				end else if (char_byte == gcp_pkg::CH_L) begin
					sel_d   = 1'b1;
					phase_d = gcp_pkg::PH_NUM;
				end else begin
					phase_d = gcp_pkg::PH_FAIL;
				end
			end
			gcp_pkg::PH_NUM: begin
				if (char_byte == gcp_pkg::CH_SLASH) begin
					if (nc_q == '0 || (nc_q == NCW'(1) && neg_q))
						phase_d = gcp_pkg::PH_FAIL;
					else
						phase_d = gcp_pkg::PH_DONE;
				end else if (nc_q >= NCW'(MAX_NUMBER_CHARS)) begin
					phase_d = gcp_pkg::PH_FAIL;
				end else begin
					nc_d = nc_q + NCW'(1);
					if (char_byte == gcp_pkg::CH_MINUS && nc_q == '0) begin
						neg_d = 1'b1;
					end else if (char_byte == gcp_pkg::CH_POINT) begin
						if (point_q)
							phase_d = gcp_pkg::PH_FAIL;
						else
							point_d = 1'b1;
					end else if (is_digit) begin
						if (!point_q) begin
							sum = mag_ext * TEN + digit * INT_SCALE;
						end else if (fd_q < FDW'(FRACTION_DIGITS)) begin
							sum  = mag_ext + digit * frac_scale;
							fd_d = fd_q + FDW'(1);
						end
						mag_d = (sum > gcp_pkg::SUM_W'(gcp_pkg::MAG_MAX)) ?
							gcp_pkg::MAG_MAX : sum[gcp_pkg::MAG_W-1:0];
					end else begin
						phase_d = gcp_pkg::PH_FAIL;
					end
				end
			end
			default: ;
		endcase

		if (is_final) begin
			ok    = (phase_d == gcp_pkg::PH_DONE);
			value = neg_d ? (gcp_pkg::GAIN_W'(0) - {1'b0, mag_d}) : {1'b0, mag_d};
			if (ok) begin
				if (sel_d)
					lin_d = value;
				else
					ang_d = value;
			end
		end

		result.status      = !ok;
		result.target_gain = ok & sel_d;
		result.angular     = ang_d;
		result.linear      = lin_d;

		if (is_final) begin
			phase_d = gcp_pkg::PH_AT;
			nc_d    = '0;
			sel_d   = 1'b0;
			neg_d   = 1'b0;
			point_d = 1'b0;
			fd_d    = '0;
			mag_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gcp_pkg::PH_AT;
			nc_q    <= '0;
			sel_q   <= 1'b0;
			neg_q   <= 1'b0;
			point_q <= 1'b0;
			fd_q    <= '0;
			mag_q   <= '0;
			ang_q   <= '0;
			lin_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			nc_q    <= nc_d;
			sel_q   <= sel_d;
			neg_q   <= neg_d;
			point_q <= point_d;
			fd_q    <= fd_d;
			mag_q   <= mag_d;
			ang_q   <= ang_d;
			lin_q   <= lin_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nc_q <= NCW'(MAX_NUMBER_CHARS))
		else $error("number character count beyond limit");

	a_fd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fd_q <= FDW'(FRACTION_DIGITS))
		else $error("fraction digit count beyond limit");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_final |=> phase_q == gcp_pkg::PH_AT && mag_q == '0)
		else $error("parse state not cleared after final word");

endmodule

### src/gain_command_parser.sv
// ----------------------------------------------------------------------------
// gain_command_parser: byte-wise parser for F/L gain commands
// Checks each command and keeps the angular and linear gains in thousandths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per command character,
//   char_byte plus is_final on the last character. Output channel
//   (out_valid/out_ready) carries one result word per final character:
//   status, target_gain and both current gains.
//   Throughput: one input word per cycle while no final word is held back.
//   A word is registered in the input register on accept and parsed when it
//   steps the core; a final word's result is registered in the output register.
//   The parse is one registered pass; an integer digit is a multiply by ten,
//   a fraction digit adds a scaled digit, both with a saturating compare.
//   Stall: while a result waits on out_ready, non-final words keep flowing;
//   a final word waits in the input register and in_ready drops only then.
//   Reset: parse returns to expecting '@', both gains clear to zero, no
//   result pending.
// ----------------------------------------------------------------------------
module gain_command_parser #(
	parameter int MAX_NUMBER_CHARS = 31,
	parameter int FRACTION_DIGITS  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        target_gain,
	output logic signed [31:0] angular_gain_milli,
	output logic signed [31:0] linear_gain_milli
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             final_s1;
	logic             step;
	logic             out_valid_q;
	gcp_pkg::result_t res;
	gcp_pkg::result_t res_q;

	assign step     = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	gcp_parse_core #(
		.MAX_NUMBER_CHARS (MAX_NUMBER_CHARS),
		.FRACTION_DIGITS  (FRACTION_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_byte (char_s1),
		.is_final  (final_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_byte;
			final_s1 <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && final_s1) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = res_q.status;
	assign target_gain        = res_q.target_gain;
	assign angular_gain_milli = signed'(res_q.angular);
	assign linear_gain_milli  = signed'(res_q.linear);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && final_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked final word");

	a_nonfinal_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && !final_s1 && !out_valid_q |=> !out_valid_q)
		else $error("result raised by a non-final word");

	a_fail_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status |-> !res_q.target_gain)
		else $error("target set on a rejected command");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gain command parser
// Feeds command strings one word per character over the input channel and
// checks every result word against a cycle-free model of the parser. Runs
// directed commands, then random well-formed, broken and noise commands under
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NUM_CHARS_MAX = 31;
	localparam int FRAC_DIGITS   = 3;
	localparam int HOLD_LEN      = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_WORDS   = 460;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} cmd_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte = 8'h00;
	logic        is_final = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic        target_gain;
	logic signed [31:0] angular_gain_milli;
	logic signed [31:0] linear_gain_milli;

	cmd_word_t          cmd_words [$];
	gcp_pkg::result_t   gain_results [$];
	logic        in_fire = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int          hold_cnt = 0;
	int          errors = 0;
	int          cycle_cnt = 0;
	int          words_queued = 0;

	// parser model state
	gcp_pkg::phase_t ph = gcp_pkg::PH_AT;
	int          num_chars = 0;
	logic        sel_l = 1'b0;
	logic        neg = 1'b0;
	logic        point = 1'b0;
	int          frac = 0;
	logic [63:0] mag = '0;
	logic [31:0] ang_gain = '0;
	logic [31:0] lin_gain = '0;

	gain_command_parser #(
		.MAX_NUMBER_CHARS(NUM_CHARS_MAX),
		.FRACTION_DIGITS (FRAC_DIGITS)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.char_byte         (char_byte),
		.is_final          (is_final),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.target_gain       (target_gain),
		.angular_gain_milli(angular_gain_milli),
		.linear_gain_milli (linear_gain_milli)
	);

	always #1 clk = ~clk;

	task automatic parse_char(input logic [7:0] c, input logic fin);
		gcp_pkg::result_t r;
		logic [63:0] m;
		logic [63:0] scale;
		logic [31:0] v;
		int          k;
		case (ph)
			gcp_pkg::PH_AT: begin
				ph = (c == gcp_pkg::CH_AT) ? gcp_pkg::PH_SEL : gcp_pkg::PH_FAIL;
			end
			gcp_pkg::PH_SEL: begin
				if (c == gcp_pkg::CH_F) begin
					sel_l = 1'b0;
					ph = gcp_pkg::PH_NUM;
				end else if (c == gcp_pkg::CH_L) begin
					sel_l = 1'b1;
					ph = gcp_pkg::PH_NUM;
				end else begin
					ph = gcp_pkg::PH_FAIL;
				end
			end
			gcp_pkg::PH_NUM: begin
				if (c == gcp_pkg::CH_SLASH) begin
					if (num_chars == 0 || (num_chars == 1 && neg))
						ph = gcp_pkg::PH_FAIL;
					else
						ph = gcp_pkg::PH_DONE;
				end else if (num_chars >= NUM_CHARS_MAX) begin
					ph = gcp_pkg::PH_FAIL;
				end else begin
					num_chars++;
					if (c == gcp_pkg::CH_MINUS && num_chars == 1) begin
						neg = 1'b1;
					end else if (c == gcp_pkg::CH_POINT) begin
						if (point)
							ph = gcp_pkg::PH_FAIL;
						else
							point = 1'b1;
					end else if (c >= gcp_pkg::CH_ZERO && c <= gcp_pkg::CH_NINE) begin
						m = mag;
						if (!point) begin
							scale = 1;
							for (k = 0; k < FRAC_DIGITS; k++)
								scale = scale * 10;
							m = m * 10 + 64'(c - gcp_pkg::CH_ZERO) * scale;
						end else if (frac < FRAC_DIGITS) begin
							scale = 1;
							for (k = 0; k < FRAC_DIGITS - 1 - frac; k++)
								scale = scale * 10;
							m = m + 64'(c - gcp_pkg::CH_ZERO) * scale;
							frac++;
						end
						mag = (m > 64'(gcp_pkg::MAG_MAX)) ? 64'(gcp_pkg::MAG_MAX) : m;
					end else begin
						ph = gcp_pkg::PH_FAIL;
					end
				end
			end
			default: ;
		endcase
		if (fin) begin
			if (ph == gcp_pkg::PH_DONE) begin
				v = neg ? (32'd0 - mag[31:0]) : mag[31:0];
				if (sel_l)
					lin_gain = v;
				else
					ang_gain = v;
			end
			r.status      = (ph == gcp_pkg::PH_DONE) ? 1'b0 : 1'b1;
			r.target_gain = (ph == gcp_pkg::PH_DONE) ? sel_l : 1'b0;
			r.angular     = ang_gain;
			r.linear      = lin_gain;
			gain_results.push_back(r);
			ph = gcp_pkg::PH_AT;
			num_chars = 0;
			sel_l = 1'b0;
			neg = 1'b0;
			point = 1'b0;
			frac = 0;
			mag = '0;
		end
	endtask

	task automatic push_word(input logic [7:0] c, input logic fin);
		cmd_word_t w;
		w.ch  = c;
		w.fin = fin;
		cmd_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_str(input string s, input logic fin_last);
		int i;
		for (i = 0; i < s.len(); i++)
			push_word(s[i], fin_last && (i == s.len() - 1));
	endtask

	task automatic gen_command();
		logic [7:0] b [$];
		int         r;
		int         len_sel;
		int         n;
		int         pt_pos;
		int         i;
		logic       minus;
		r = $urandom_range(99);
		if (r < 8) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				b.push_back(8'($urandom));
		end else begin
			b.push_back(gcp_pkg::CH_AT);
			b.push_back($urandom_range(1) ? gcp_pkg::CH_L : gcp_pkg::CH_F);
			len_sel = $urandom_range(99);
			if (len_sel < 4)
				n = 0;
			else if (len_sel < 80)
				n = $urandom_range(1, 8);
			else if (len_sel < 90)
				n = $urandom_range(9, 16);
			else
				n = $urandom_range(29, 33);
			minus = ($urandom_range(2) == 0);
			pt_pos = $urandom_range(1) ? $urandom_range(n) : -1;
			for (i = 0; i < n; i++) begin
				if (i == 0 && minus)
					b.push_back(gcp_pkg::CH_MINUS);
				else if (i == pt_pos)
					b.push_back(gcp_pkg::CH_POINT);
				else
					b.push_back(gcp_pkg::CH_ZERO + 8'($urandom_range(9)));
			end
			if (n > 1 && $urandom_range(24) == 0)
				b[2 + $urandom_range(n - 1)] = gcp_pkg::CH_POINT;
			if ($urandom_range(19) != 0)
				b.push_back(gcp_pkg::CH_SLASH);
			repeat ($urandom_range(3))
				b.push_back(8'($urandom));
			if (r < 22)
				b[$urandom_range(b.size() - 1)] = 8'($urandom);
		end
		for (i = 0; i < b.size(); i++)
			push_word(b[i], i == b.size() - 1);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (cmd_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid  <= 1'b1;
				char_byte <= cmd_words[0].ch;
				is_final  <= cmd_words[0].fin;
				void'(cmd_words.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output ready, with long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_cnt  <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		gcp_pkg::result_t e;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (gain_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: status=%0d tgt=%0d ang=%0d lin=%0d",
						status, target_gain, angular_gain_milli, linear_gain_milli);
			end else begin
				e = gain_results.pop_front();
				if (status !== e.status || target_gain !== e.target_gain ||
						angular_gain_milli !== e.angular || linear_gain_milli !== e.linear) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st/tgt/ang/lin %0d/%0d/%0d/%0d, %s %0d/%0d/%0d/%0d",
							e.status, e.target_gain, $signed(e.angular), $signed(e.linear),
							"got", status, target_gain, angular_gain_milli,
							linear_gain_milli);
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			parse_char(char_byte, is_final);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int send_tab [4];
		int recv_tab [4];
		int p;
		int start;
		send_tab = '{0, 55, 0, 15};
		recv_tab = '{0, 0, 55, 15};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (p = 0; p < 4; p++) begin
			send_idle_pct  = send_tab[p];
			recv_stall_pct = recv_tab[p];
			start = words_queued;
			if (p == 0) begin
				push_word(8'hFF, 1'b1);
				push_str("@F/", 1'b1);
				push_str("@F1/", 1'b1);
				push_str("@L-2.5/", 1'b1);
				push_str("@F./", 1'b1);
				push_str("@L-./", 1'b1);
				push_str("@F-/", 1'b1);
				push_str("@F1.2.3/", 1'b1);
				push_str("@F", 1'b0);
				push_word(8'h00, 1'b0);
				push_str("/", 1'b1);
				push_str("@L99999999999/", 1'b1);
				push_str("@F-99999999999/", 1'b1);
				push_str("@F1.23456/", 1'b1);
				push_str("@L1234567890123456789012345678901/", 1'b1);
				push_str("@L12345678901234567890123456789012/", 1'b1);
				push_str("@F5", 1'b1);
				push_str("@F7/xy", 1'b0);
				push_word(8'hFF, 1'b1);
				push_str("#F1/", 1'b1);
				push_str("@X1/", 1'b1);
			end
			while (words_queued - start < PHASE_WORDS)
				gen_command();
			if (p == 0)
				hold_req = ~hold_req;
			// sender waits for the pipeline to drain before the next mix
			while (cmd_words.size() != 0 || in_valid)
				@(posedge clk);
			while (gain_results.size() != 0)
				@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (gain_results.size() != 0)
			errors++;
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
